>>> rtl/core/pmpf_pkg.sv
package pmpf_pkg;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COLOR_W     = 2;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] FRAME_START = 8'h7C;
  localparam logic [BYTE_W-1:0] FRAME_END   = 8'h7D;

  localparam logic [SIZE_W-1:0] SIZE_MIN  = 6'd5;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = 6'd50;
  localparam logic [SIZE_W-1:0] SIZE_STEP = 6'd5;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 2'd1;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd5;

  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERASE_A = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CALIB   = 3'd4;

  // x / 410 == (x * 81841) >> 25 for 0 <= x <= 32768
  localparam logic [16:0] ACCEL_RECIP = 17'd81841;
  localparam int unsigned ACCEL_SHIFT = 25;

  localparam logic IN_FUNC_BUTTON = 1'b0;
  localparam logic IN_FUNC_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    MENU_INIT      = 4'd0,
    MENU_DEFAULT   = 4'd1,
    MENU_PRESS1    = 4'd2,
    MENU_PRESS2    = 4'd3,
    MENU_PRESS3    = 4'd4,
    MENU_CALIB     = 4'd5,
    MENU_COLOR     = 4'd6,
    MENU_SIZE      = 4'd7,
    MENU_WRITE     = 4'd8,
    MENU_ERASE     = 4'd9,
    MENU_ERASE_ALL = 4'd10
  } menu_state_t;

  typedef enum logic [2:0] {
    POS_START = 3'd0,
    POS_DX    = 3'd1,
    POS_DY    = 3'd2,
    POS_COLOR = 3'd3,
    POS_SIZE  = 3'd4,
    POS_MODE  = 3'd5,
    POS_END   = 3'd6
  } frame_pos_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  dx;
    logic [BYTE_W-1:0]  dy;
    logic [COLOR_W-1:0] color;
    logic [SIZE_W-1:0]  size;
    logic [MODE_W-1:0]  mode;
  } frame_entry_t;

  typedef struct packed {
    logic         valid;
    frame_entry_t data;
  } queue_head_t;

  function automatic logic [BYTE_W-1:0] scale_axis(input logic [AXIS_W-1:0] raw);
    logic [AXIS_W:0]      mag;
    logic [2*AXIS_W+1:0]  prod;
    logic [BYTE_W-1:0]    quo;
    mag  = raw[AXIS_W-1] ? (17'd0 - {1'b1, raw}) : {1'b0, raw};
    prod = {1'b0, mag} * {1'b0, ACCEL_RECIP};
    quo  = prod[ACCEL_SHIFT +: BYTE_W];
    return raw[AXIS_W-1] ? (8'd0 - quo) : quo;
  endfunction

endpackage

>>> rtl/core/pmpf_front.sv
module pmpf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pmpf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic                                queue_full,
  output logic                                push,
  output pmpf_pkg::frame_entry_t              push_data
);

  pmpf_pkg::menu_state_t                menu_r, menu_nxt;
  logic [pmpf_pkg::COLOR_W-1:0]         color_r, color_nxt;
  logic [pmpf_pkg::SIZE_W-1:0]          size_r, size_nxt;
  logic [pmpf_pkg::MODE_W-1:0]          mode_r, mode_nxt;
  logic                                 accept;
  logic                                 p1, p2, p3;
  logic [pmpf_pkg::AXIS_W-1:0]          ax, ay;
  logic [pmpf_pkg::SIZE_W:0]            size_up;

  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;
  assign p1        = in_tdata[0];
  assign p2        = in_tdata[1];
  assign p3        = in_tdata[2];
  assign ax        = in_tdata[3 +: pmpf_pkg::AXIS_W];
  assign ay        = in_tdata[3 + pmpf_pkg::AXIS_W +: pmpf_pkg::AXIS_W];

  assign push            = accept && (in_tuser == pmpf_pkg::IN_FUNC_SAMPLE);
  assign push_data.dx    = pmpf_pkg::scale_axis(ax);
  assign push_data.dy    = pmpf_pkg::scale_axis(ay);
  assign push_data.color = color_r;
  assign push_data.size  = size_r;
  assign push_data.mode  = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r  <= pmpf_pkg::MENU_INIT;
      color_r <= pmpf_pkg::COLOR_RESET;
      size_r  <= pmpf_pkg::SIZE_RESET;
      mode_r  <= pmpf_pkg::MODE_WRITE;
    end else if (accept && (in_tuser == pmpf_pkg::IN_FUNC_BUTTON)) begin
      menu_r  <= menu_nxt;
      color_r <= color_nxt;
      size_r  <= size_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    menu_nxt  = menu_r;
    color_nxt = color_r;
    size_nxt  = size_r;
    mode_nxt  = mode_r;
    size_up   = {1'b0, size_r} + {1'b0, pmpf_pkg::SIZE_STEP};
    unique case (menu_r)
      pmpf_pkg::MENU_INIT: begin
        menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      pmpf_pkg::MENU_DEFAULT: begin
        mode_nxt = pmpf_pkg::MODE_IDLE;
        priority if (p1) menu_nxt = pmpf_pkg::MENU_PRESS1;
        else if (p2) menu_nxt = pmpf_pkg::MENU_PRESS2;
        else if (p3) menu_nxt = pmpf_pkg::MENU_PRESS3;
        else menu_nxt = menu_r;
      end
      pmpf_pkg::MENU_PRESS1: begin
        priority if (p2) menu_nxt = pmpf_pkg::MENU_CALIB;
        else if (p1) menu_nxt = pmpf_pkg::MENU_WRITE;
        else if (p3) menu_nxt = pmpf_pkg::MENU_DEFAULT;
        else menu_nxt = menu_r;
      end
      pmpf_pkg::MENU_PRESS2: begin
        priority if (p2) menu_nxt = pmpf_pkg::MENU_COLOR;
        else if (p1) menu_nxt = pmpf_pkg::MENU_SIZE;
        else if (p3) menu_nxt = pmpf_pkg::MENU_DEFAULT;
        else menu_nxt = menu_r;
      end
      pmpf_pkg::MENU_PRESS3: begin
        priority if (p2) menu_nxt = pmpf_pkg::MENU_ERASE;
        else if (p1) menu_nxt = pmpf_pkg::MENU_ERASE_ALL;
        else if (p3) menu_nxt = pmpf_pkg::MENU_DEFAULT;
        else menu_nxt = menu_r;
      end
      pmpf_pkg::MENU_CALIB: begin
        mode_nxt = pmpf_pkg::MODE_CALIB;
        if (p1) menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      pmpf_pkg::MENU_COLOR: begin
        color_nxt = color_r + {1'b0, p2} - {1'b0, p3};
        if (p1) menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      pmpf_pkg::MENU_SIZE: begin
        if (p2) begin
          size_nxt = (size_up > {1'b0, pmpf_pkg::SIZE_MAX}) ? pmpf_pkg::SIZE_MAX
                                                              : size_up[pmpf_pkg::SIZE_W-1:0];
        end
        if (p3) begin
          size_nxt = (size_nxt < (pmpf_pkg::SIZE_MIN + pmpf_pkg::SIZE_STEP)) ?
                     pmpf_pkg::SIZE_MIN : (size_nxt - pmpf_pkg::SIZE_STEP);
        end
        if (p1) menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      pmpf_pkg::MENU_WRITE: begin
        mode_nxt = pmpf_pkg::MODE_WRITE;
        if (p1) menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      pmpf_pkg::MENU_ERASE: begin
        mode_nxt = pmpf_pkg::MODE_ERASE;
        if (p1) menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      pmpf_pkg::MENU_ERASE_ALL: begin
        mode_nxt = pmpf_pkg::MODE_ERASE_A;
        if (p1) menu_nxt = pmpf_pkg::MENU_DEFAULT;
      end
      default: begin
        menu_nxt = menu_r;
      end
    endcase
  end

endmodule

>>> rtl/core/pmpf_queue.sv
module pmpf_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  pmpf_pkg::frame_entry_t  push_data,
  output logic                    full,
  input  logic                    pop,
  output pmpf_pkg::queue_head_t   head
);

  localparam int unsigned DEPTH = pmpf_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pmpf_pkg::frame_entry_t mem [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.data  = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/core/pmpf_back.sv
module pmpf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pmpf_pkg::queue_head_t               head,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pmpf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  pmpf_pkg::frame_pos_t                 pos_r, pos_nxt;
  logic                                 valid_r, valid_nxt;
  logic [pmpf_pkg::BYTE_W-1:0]          byte_r, byte_nxt;
  logic                                 last_r, last_nxt;
  logic                                 load;

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign load       = head.valid && (!valid_r || out_tready);
  assign pop        = load && (pos_r == pmpf_pkg::POS_END);

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (out_tready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = (pos_r == pmpf_pkg::POS_END);
      pos_nxt   = (pos_r == pmpf_pkg::POS_END) ? pmpf_pkg::POS_START
                                               : pmpf_pkg::frame_pos_t'(pos_r + 3'd1);
      unique case (pos_r)
        pmpf_pkg::POS_START: byte_nxt = pmpf_pkg::FRAME_START;
        pmpf_pkg::POS_DX:    byte_nxt = head.data.dx;
        pmpf_pkg::POS_DY:    byte_nxt = head.data.dy;
        pmpf_pkg::POS_COLOR: byte_nxt = {6'd0, head.data.color};
        pmpf_pkg::POS_SIZE:  byte_nxt = {2'd0, head.data.size};
        pmpf_pkg::POS_MODE:  byte_nxt = {5'd0, head.data.mode};
        pmpf_pkg::POS_END:   byte_nxt = pmpf_pkg::FRAME_END;
        default:             byte_nxt = pmpf_pkg::FRAME_END;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= pmpf_pkg::POS_START;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

>>> rtl/core/pen_menu_and_packet_framer_core.sv
// Button items: one per cycle, menu state updated at the accepting edge, no output.
// Sample items: written into the frame queue on accept, then each frame byte is registered
// in the output stage, seven bytes on consecutive cycles when out_tready stays high;
// a two-entry frame queue lets samples be taken while earlier frames drain.
// in_tready is low while the queue is full, which holds button items as well.
// Synchronous active-low reset: menu to initial state, color 1, size 5, mode 1, queue empty.
module pen_menu_and_packet_framer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] press_one, [1] press_two, [2] press_three, [18:3] accel_x, [34:19] accel_y
  input  logic [pmpf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] func
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] frame_byte
  output logic [pmpf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  logic                    queue_full;
  logic                    push;
  logic                    pop;
  pmpf_pkg::frame_entry_t  push_data;
  pmpf_pkg::queue_head_t   head;

  pmpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  pmpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  pmpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
